FILE: rtl/text_console_char_writer_unit_assert.svh
// assertion macros for the text console character writer
// no dependencies; included by modules that carry concurrent checks
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TCCW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tccw check failed");
`define TCCW_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tccw check failed");
`else
`define TCCW_ASSERT(lbl, clk, rst, prop)
`define TCCW_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

FILE: rtl/tccw_pkg.sv
// shared constants for the text console character writer
// no dependencies; imported by text_console_char_writer_unit
package tccw_pkg;

  localparam int TAB_WIDTH_DEF = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] ATTR_MASK = 16'h7f00;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_LINES   = 2'd1;
  localparam logic [1:0] REG_ATTR    = 2'd2;

  localparam logic [7:0]  COLUMNS_RST = 8'd80;
  localparam logic [7:0]  LINES_RST   = 8'd25;
  localparam logic [15:0] ATTR_RST    = 16'h0700;

  localparam logic signed [17:0] COL_MAX = 18'sd32767;
  localparam logic signed [17:0] COL_MIN = -18'sd32768;

endpackage

FILE: rtl/text_console_char_writer_unit.sv
// text console character writer: cursor tracking and fill run generation
// depends on tccw_pkg and text_console_char_writer_unit_assert.svh
//
// usage:
//   input channel (in_valid/in_ready) carries one character beat: char_code
//   and attr_code. output channel (out_valid/out_ready) carries one result
//   beat per character: a fill run (fill_row, fill_col, fill_count,
//   fill_cell) for an external text buffer and the cursor after the char.
//   fill_count of 0 means nothing to write; row, column and cell are 0 then.
//   a result beat appears in the cycle after its input beat; one character
//   is taken every cycle while out_ready is high, set by the single result
//   register after the cursor update logic. in_ready stays high while the
//   result register is empty or being drained in the same cycle, so a
//   stalled receiver holds one result and then stops the input side.
//   the apb port sets screen_columns (0x0), screen_lines (0x4) and
//   default_attr_word (0x8); write it only while the block is idle.
//   synchronous reset puts the cursor at row 0, column 0, empties the
//   result register and loads 80 columns, 25 lines and attribute 0x0700.
module text_console_char_writer_unit
  import tccw_pkg::*;
#(
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic [7:0]          attr_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          fill_row,
  output logic [7:0]          fill_col,
  output logic [7:0]          fill_count,
  output logic [15:0]         fill_cell,
  output logic signed [15:0]  cursor_col,
  output logic [7:0]          cursor_row,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  `include "text_console_char_writer_unit_assert.svh"

  localparam int MW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int SAT_MOD = 32767 % TAB_WIDTH;

  logic [7:0]         screen_columns;
  logic [7:0]         screen_lines;
  logic [15:0]        default_attr_word;
  logic signed [15:0] col_pos;
  logic signed [15:0] col_pos_next;
  logic [7:0]         row_pos;
  logic [7:0]         row_pos_next;
  logic [MW-1:0]      col_mod;
  logic [MW-1:0]      col_mod_next;

  logic               in_fire;
  logic               cfg_wr;
  logic [15:0]        word;
  logic signed [17:0] col_ext;
  logic signed [17:0] cols_ext;
  logic [MW:0]        tab_step;
  logic signed [17:0] run_hi;
  logic signed [17:0] lo_clip;
  logic signed [17:0] hi_clip;
  logic signed [17:0] run_len;
  logic               do_fill;
  logic               run_ok;
  logic [7:0]         run_char;
  logic [8:0]         row_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (paddr[3:2])
      REG_COLUMNS: prdata = {24'd0, screen_columns};
      REG_LINES:   prdata = {24'd0, screen_lines};
      REG_ATTR:    prdata = {16'd0, default_attr_word};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns    <= COLUMNS_RST;
      screen_lines      <= LINES_RST;
      default_attr_word <= ATTR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COLUMNS: screen_columns    <= pwdata[7:0];
        REG_LINES:   screen_lines      <= pwdata[7:0];
        REG_ATTR:    default_attr_word <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // cursor update and fill run
  assign word     = (attr_code != 8'd0) ? ({attr_code, 8'd0} & ATTR_MASK) : default_attr_word;
  assign col_ext  = {{2{col_pos[15]}}, col_pos};
  assign cols_ext = {10'd0, screen_columns};
  assign tab_step = (MW+1)'(TAB_WIDTH) - {1'b0, col_mod};
  assign row_inc  = {1'b0, row_pos} + 9'd1;

  always_comb begin
    run_hi       = col_ext + 18'sd1;
    do_fill      = 1'b1;
    run_char     = char_code;
    col_pos_next = col_pos;
    col_mod_next = col_mod;
    row_pos_next = row_pos;
    case (char_code)
      CH_TAB: begin
        run_hi   = col_ext + $signed({{(17-MW){1'b0}}, tab_step});
        run_char = CH_SPACE;
        if (run_hi > COL_MAX) begin
          col_pos_next = 16'sd32767;
          col_mod_next = MW'(SAT_MOD);
        end else begin
          col_pos_next = run_hi[15:0];
          col_mod_next = '0;
        end
      end
      CH_BS: begin
        do_fill = 1'b0;
        if (col_ext - 18'sd1 >= COL_MIN) begin
          col_pos_next = col_pos - 16'sd1;
          col_mod_next = (col_mod == '0) ? MW'(TAB_WIDTH - 1) : col_mod - MW'(1);
        end
      end
      CH_CR: begin
        do_fill      = 1'b0;
        col_pos_next = '0;
        col_mod_next = '0;
      end
      CH_LF: begin
        run_hi       = cols_ext;
        run_char     = CH_SPACE;
        col_pos_next = '0;
        col_mod_next = '0;
        row_pos_next = (row_inc >= {1'b0, screen_lines}) ? 8'd0 : row_inc[7:0];
      end
      default: begin
        if (run_hi <= COL_MAX) begin
          col_pos_next = run_hi[15:0];
          col_mod_next = (col_mod == MW'(TAB_WIDTH - 1)) ? '0 : col_mod + MW'(1);
        end
      end
    endcase
  end

  assign lo_clip = col_ext[17] ? 18'sd0 : col_ext;
  assign hi_clip = (run_hi > cols_ext) ? cols_ext : run_hi;
  assign run_len = hi_clip - lo_clip;
  assign run_ok  = do_fill && (hi_clip > lo_clip) && (row_pos < screen_lines);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      col_mod   <= '0;
      row_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        col_pos   <= col_pos_next;
        col_mod   <= col_mod_next;
        row_pos   <= row_pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fill_row   <= run_ok ? row_pos : 8'd0;
      fill_col   <= run_ok ? lo_clip[7:0] : 8'd0;
      fill_count <= run_ok ? run_len[7:0] : 8'd0;
      fill_cell  <= run_ok ? ({8'd0, run_char} | word) : 16'd0;
      cursor_col <= col_pos_next;
      cursor_row <= row_pos_next;
    end
  end

  `TCCW_ASSERT(a_fire_gives_beat, clk, rst, in_fire |=> out_valid)
  `TCCW_ASSERT(a_empty_run_zero, clk, rst, (out_valid && fill_count == 8'd0) |-> (fill_row == 8'd0 && fill_col == 8'd0 && fill_cell == 16'd0))
  `TCCW_ASSERT(a_run_in_range, clk, rst, (out_valid && fill_count != 8'd0) |-> (({1'b0, fill_col} + {1'b0, fill_count}) <= 9'd255))
  `TCCW_ASSERT(a_row_tracks, clk, rst, out_valid |-> (cursor_row == row_pos))
  `TCCW_ASSERT_NORST(a_reset_empties, clk, rst |=> !out_valid)

endmodule

FILE: bench/text_console_char_writer_unit_test.sv
// self-checking bench for text_console_char_writer_unit: random and directed character beats,
// cursor and fill runs predicted in the bench, apb writes between phases
// depends on tccw_pkg and the rtl of text_console_char_writer_unit
module text_console_char_writer_unit_test;
  import tccw_pkg::*;

  localparam int TABW = TAB_WIDTH_DEF;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] at;
  } char_beat_t;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic [7:0]         count;
    logic [15:0]        cword;
    logic signed [15:0] ccol;
    logic [7:0]         crow;
  } fill_run_t;

  logic clk;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          char_code = 8'h00;
  logic [7:0]          attr_code = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          fill_row;
  logic [7:0]          fill_col;
  logic [7:0]          fill_count;
  logic [15:0]         fill_cell;
  logic signed [15:0]  cursor_col;
  logic [7:0]          cursor_row;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  char_beat_t char_backlog[$];
  fill_run_t  pending_fills[$];

  // cursor and screen shadow
  int cur_col = 0;
  int cur_row = 0;
  int scr_cols = COLUMNS_RST;
  int scr_lines = LINES_RST;
  int dflt_word = ATTR_RST;

  int send_idle_pct = 14;
  int recv_idle_pct = 50;
  int in_beats = 0;
  int mismatches = 0;
  logic hold_rx = 1'b0;

  text_console_char_writer_unit #(.TAB_WIDTH(TABW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .attr_code(attr_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .fill_row(fill_row), .fill_col(fill_col), .fill_count(fill_count),
    .fill_cell(fill_cell), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clamp_col(input int v);
    if (v > int'(COL_MAX)) return int'(COL_MAX);
    if (v < int'(COL_MIN)) return int'(COL_MIN);
    return v;
  endfunction

  function automatic fill_run_t advance_cursor(input logic [7:0] ch, input logic [7:0] at);
    fill_run_t r;
    int word, lo, hi, a, b, m, cnt, cw, old_row;
    word = (at != 8'h00) ? int'({at, 8'h00} & ATTR_MASK) : dflt_word;
    old_row = cur_row;
    lo = 0;
    hi = 0;
    cw = 0;
    case (ch)
      CH_TAB: begin
        m = cur_col % TABW;
        if (m < 0) m += TABW;
        lo = cur_col;
        hi = cur_col + TABW - m;
        cw = int'(CH_SPACE) | word;
        cur_col = clamp_col(hi);
      end
      CH_BS: cur_col = clamp_col(cur_col - 1);
      CH_CR: cur_col = 0;
      CH_LF: begin
        lo = cur_col;
        hi = scr_cols;
        cw = int'(CH_SPACE) | word;
        cur_row = (cur_row + 1 >= scr_lines) ? 0 : cur_row + 1;
        cur_col = 0;
      end
      default: begin
        lo = cur_col;
        hi = cur_col + 1;
        cw = int'(ch) | word;
        cur_col = clamp_col(hi);
      end
    endcase
    a = (lo < 0) ? 0 : lo;
    b = (hi > scr_cols) ? scr_cols : hi;
    cnt = (b <= a || old_row >= scr_lines) ? 0 : b - a;
    r = '0;
    if (cnt != 0) begin
      r.row = old_row[7:0];
      r.col = a[7:0];
      r.cword = cw[15:0];
    end
    r.count = cnt[7:0];
    r.ccol = cur_col[15:0];
    r.crow = cur_row[7:0];
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // input driver
  always @(posedge clk) begin : beat_driver
    char_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_fills.push_back(advance_cursor(char_code, attr_code));
        in_beats++;
      end
      if (!in_valid || in_ready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = char_backlog.pop_front();
          in_valid <= 1'b1;
          char_code <= nxt.ch;
          attr_code <= nxt.at;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : fill_checker
    fill_run_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {fill_row, fill_col, fill_count, fill_cell, cursor_col, cursor_row};
        if (pending_fills.size() == 0) begin
          flag_failure($sformatf("result beat with nothing expected: row %0d col %0d count %0d",
                                 got.row, got.col, got.count));
        end else begin
          want = pending_fills.pop_front();
          if (got !== want)
            flag_failure($sformatf({"mismatch: expected row %0d col %0d count %0d cell %h ",
                                    "cursor %0d,%0d got row %0d col %0d count %0d cell %h ",
                                    "cursor %0d,%0d"},
                                   want.row, want.col, want.count, want.cword, want.ccol,
                                   want.crow, got.row, got.col, got.count, got.cword,
                                   got.ccol, got.crow));
        end
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall while the sender keeps offering beats
  initial begin : receiver_hold
    int n;
    wait (in_beats >= 150);
    @(posedge clk);
    hold_rx <= 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic apb_write(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COLUMNS: scr_cols = val & 32'hff;
      REG_LINES:   scr_lines = val & 32'hff;
      REG_ATTR:    dflt_word = val & 32'hffff;
      default: ;
    endcase
  endtask

  task automatic set_screen(input int unsigned c, input int unsigned l, input int unsigned a);
    apb_write(REG_COLUMNS, c);
    apb_write(REG_LINES, l);
    apb_write(REG_ATTR, a);
  endtask

  task automatic wait_idle();
    while (char_backlog.size() != 0 || in_valid || pending_fills.size() != 0) @(posedge clk);
  endtask

  task automatic push_beat(input logic [7:0] ch, input logic [7:0] at);
    char_beat_t b;
    b.ch = ch;
    b.at = at;
    char_backlog.push_back(b);
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(3))
      0: return 1;
      1: return 255;
      2: return $urandom_range(1, 12);
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  task automatic push_random_beats(input int n);
    int k, sel, j, run;
    logic [7:0] at;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      at = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
      if (sel < 2) begin
        // long run of tabs or backspaces to push the cursor far out
        run = $urandom_range(10, 40);
        for (j = 0; j < run; j++) push_beat(($urandom_range(1) != 0) ? CH_TAB : CH_BS, at);
      end else if (sel < 12) push_beat(CH_TAB, at);
      else if (sel < 22) push_beat(CH_BS, at);
      else if (sel < 27) push_beat(CH_CR, at);
      else if (sel < 34) push_beat(CH_LF, at);
      else push_beat(8'($urandom_range(255)), at);
    end
  endtask

  initial begin : stimulus
    int k, phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: printable, attributes, controls, negative column
    push_beat("A", 8'h00);
    push_beat("B", 8'hff);
    push_beat(8'h00, 8'h01);
    push_beat(8'hff, 8'h80);
    push_beat(CH_TAB, 8'h00);
    push_beat(CH_BS, 8'h7f);
    push_beat(CH_CR, 8'h00);
    push_beat(CH_BS, 8'h00);
    push_beat(CH_BS, 8'h00);
    push_beat("x", 8'h00);
    push_beat(CH_TAB, 8'h11);
    push_beat(CH_TAB, 8'h00);
    push_beat(CH_LF, 8'h22);
    wait_idle();

    // widest screen, default word with low bits set
    set_screen(255, 255, 32'hffff);
    push_beat("Z", 8'h00);
    push_beat(CH_TAB, 8'h00);
    push_beat(CH_LF, 8'h00);
    wait_idle();

    // one cell screen
    set_screen(1, 1, 32'h0001);
    push_beat("q", 8'h00);
    push_beat("q", 8'h00);
    push_beat(CH_LF, 8'h00);
    wait_idle();

    // row left off screen by lowering the line count
    set_screen(80, 25, 32'h0700);
    push_beat(CH_LF, 8'h00);
    push_beat(CH_LF, 8'h00);
    push_beat(CH_LF, 8'h00);
    wait_idle();
    apb_write(REG_LINES, 2);
    push_beat("r", 8'h00);
    push_beat(CH_LF, 8'h00);
    push_beat("r", 8'h00);
    wait_idle();

    // zero size screen
    apb_write(REG_COLUMNS, 0);
    push_beat("a", 8'h00);
    push_beat(CH_TAB, 8'h00);
    wait_idle();
    set_screen(80, 0, 32'h0700);
    push_beat(CH_LF, 8'h00);
    push_beat("a", 8'h00);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 50;
        recv_idle_pct = 14;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_screen(pick_size(), pick_size(),
                 ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(65535));
      push_random_beats(160);
      wait_idle();
    end

    // long tab and backspace runs past both screen edges
    set_screen(255, 255, 32'h0700);
    push_beat(CH_CR, 8'h00);
    for (k = 0; k < 40; k++) push_beat(CH_TAB, 8'h00);
    push_beat("S", 8'h00);
    push_beat(CH_TAB, 8'h00);
    push_beat(CH_BS, 8'h00);
    push_beat(CH_CR, 8'h00);
    for (k = 0; k < 40; k++) push_beat(CH_BS, 8'h00);
    push_beat(CH_BS, 8'h00);
    push_beat(CH_TAB, 8'h00);
    push_beat("S", 8'h00);
    push_beat(CH_CR, 8'h00);
    push_beat("S", 8'h00);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_fills.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
